### hdl/saufp_pkg.sv
// ----------------------------------------------------------------------------
// saufp_pkg
// Shared types and constants of the SOCKS-address UDP frame parser.
// ----------------------------------------------------------------------------
package saufp_pkg;

    localparam int COUNT_W    = 17;
    localparam int WORD_W     = 16;
    localparam int M_TDATA_W  = 72;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] KIND_ADDR    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [1:0] ST_SUCCESS    = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_INVALID    = 2'd2;

    localparam logic [7:0] ATYPE_IPV4   = 8'h01;
    localparam logic [7:0] ATYPE_DOMAIN = 8'h03;
    localparam logic [7:0] ATYPE_IPV6   = 8'h04;

    localparam logic [7:0] IPV4_ADDR_LEN = 8'd4;
    localparam logic [7:0] IPV6_ADDR_LEN = 8'd16;
    localparam logic [7:0] DOMAIN_MAX    = 8'd253;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;

    localparam logic [COUNT_W-1:0] MIN_BUFFER = 17'd8;

    // type byte + address + port + length + CR LF; the domain form also has a length byte
    localparam logic [8:0] HDR_IPV4     = 9'd11;
    localparam logic [8:0] HDR_IPV6     = 9'd23;
    localparam logic [8:0] HDR_DOMAIN_0 = 9'd8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         out_byte;
        logic [7:0]         address_type;
        logic [WORD_W-1:0]  port_number;
        logic [WORD_W-1:0]  payload_length;
        logic [1:0]         status;
        logic [COUNT_W-1:0] consumed_count;
        logic               last_of_run;
    } out_item_t;

endpackage

### hdl/socks_address_udp_frame_parser.sv
// ----------------------------------------------------------------------------
// socks_address_udp_frame_parser
// Byte-serial parser for a UDP frame with a SOCKS-style address header.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one buffer byte per item; s_tlast marks the buffer's last byte.
//   m_* gives result items: m_tuser is the kind (address byte, header fields,
//   payload byte, final status), m_tlast marks the last result of a byte.
//   Each buffer yields exactly one status item; state clears after s_tlast.
// Throughput: one byte per cycle while s_tready is high. The parse is a single pass of logic on the
//   state registers; results enter a 4-entry output queue. A byte causes at
//   most two results, so s_tready is high while the queue holds two or fewer.
// Stall: when m_tready is low the queue holds its items and fills; s_tready
//   drops once a further byte could overflow it. No item is lost.
// Reset: aresetn (synchronous, active low) empties the queue and returns the
//   parser to waiting for the address type byte.
// ----------------------------------------------------------------------------
module socks_address_udp_frame_parser
    import saufp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic                 s_tlast,   // end_of_buffer
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_byte[7:0], address_type[15:8], port_number[31:16],
    // payload_length[47:32], status[49:48], consumed_count[66:50], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,   // kind
    output logic                 m_tlast    // last_of_run
);

    typedef enum logic [3:0] {
        PH_TYPE, PH_DLEN, PH_ADDR, PH_PORT_HI, PH_PORT_LO, PH_LEN_HI,
        PH_LEN_LO, PH_CR, PH_LF, PH_PAYLOAD, PH_HOLD, PH_DONE
    } phase_t;

    localparam logic [LEVEL_W-1:0] READY_LEVEL = LEVEL_W'(FIFO_DEPTH - 2);

    phase_t             phase_reg, phase_next, ph_mid;
    logic [COUNT_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         fcount_reg, fcount_next;
    logic [7:0]         dlen_reg, dlen_next;
    logic [WORD_W-1:0]  port_reg, port_next;
    logic [WORD_W-1:0]  length_reg, length_next;
    logic               inv_reg, inv_next;

    out_item_t            fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;

    logic               in_acc, pop;
    logic               data_vld, stat_vld;
    out_item_t          data_item, stat_item, first_item;
    logic [8:0]         hdr_len;
    logic [COUNT_W-1:0] frame_end;
    logic [7:0]         b;
    logic [1:0]         n_wr;
    out_item_t          head;

    assign b        = s_tdata;
    assign s_tready = (level_reg <= READY_LEVEL);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = (level_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign head    = fifo_reg[rd_ptr_reg];
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;
    assign m_tdata = {5'd0, head.consumed_count, head.status, head.payload_length,
                      head.port_number, head.address_type, head.out_byte};

    always_comb begin
        if (type_reg == ATYPE_IPV4) begin
            hdr_len = HDR_IPV4;
        end else if (type_reg == ATYPE_IPV6) begin
            hdr_len = HDR_IPV6;
        end else begin
            hdr_len = HDR_DOMAIN_0 + {1'b0, dlen_reg};
        end
        frame_end = COUNT_W'(hdr_len) + COUNT_W'(length_reg);
    end

    always_comb begin
        phase_next      = phase_reg;
        ph_mid          = phase_reg;
        bytes_seen_next = bytes_seen_reg;
        type_next       = type_reg;
        fcount_next     = fcount_reg;
        dlen_next       = dlen_reg;
        port_next       = port_reg;
        length_next     = length_reg;
        inv_next        = inv_reg;
        data_vld        = 1'b0;
        stat_vld        = 1'b0;
        data_item       = '0;
        stat_item       = '0;
        stat_item.kind  = KIND_STATUS;

        if (in_acc) begin
            if (phase_reg != PH_DONE) begin
                bytes_seen_next = bytes_seen_reg + COUNT_W'(1);
            end
            unique case (phase_reg)
                PH_TYPE: begin
                    type_next = b;
                    if (b == ATYPE_IPV4) begin
                        fcount_next = IPV4_ADDR_LEN;
                        ph_mid      = PH_ADDR;
                    end else if (b == ATYPE_IPV6) begin
                        fcount_next = IPV6_ADDR_LEN;
                        ph_mid      = PH_ADDR;
                    end else if (b == ATYPE_DOMAIN) begin
                        ph_mid = PH_DLEN;
                    end else begin
                        inv_next = 1'b1;
                        ph_mid   = PH_HOLD;
                    end
                end
                PH_DLEN: begin
                    dlen_next = b;
                    if (b == 8'd0 || b > DOMAIN_MAX) begin
                        inv_next = 1'b1;
                        ph_mid   = PH_HOLD;
                    end else begin
                        fcount_next = b;
                        ph_mid      = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    data_vld               = 1'b1;
                    data_item.kind         = KIND_ADDR;
                    data_item.out_byte     = b;
                    data_item.address_type = type_reg;
                    fcount_next            = fcount_reg - 8'd1;
                    if (fcount_next == 8'd0) begin
                        ph_mid = PH_PORT_HI;
                    end
                end
                PH_PORT_HI: begin
                    port_next = {b, 8'd0};
                    ph_mid    = PH_PORT_LO;
                end
                PH_PORT_LO: begin
                    port_next = {port_reg[15:8], b};
                    ph_mid    = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    length_next = {b, 8'd0};
                    ph_mid      = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = {length_reg[15:8], b};
                    ph_mid      = PH_CR;
                end
                PH_CR: begin
                    inv_next = (b != CHAR_CR);
                    ph_mid   = PH_LF;
                end
                PH_LF: begin
                    if (inv_reg || b != CHAR_LF) begin
                        stat_vld         = 1'b1;
                        stat_item.status = ST_INVALID;
                    end else begin
                        data_vld                 = 1'b1;
                        data_item.kind           = KIND_HEADER;
                        data_item.address_type   = type_reg;
                        data_item.port_number    = port_reg;
                        data_item.payload_length = length_reg;
                        if (length_reg == '0) begin
                            stat_vld                 = 1'b1;
                            stat_item.status         = ST_SUCCESS;
                            stat_item.consumed_count = bytes_seen_next;
                        end else begin
                            ph_mid = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    data_vld               = 1'b1;
                    data_item.kind         = KIND_PAYLOAD;
                    data_item.out_byte     = b;
                    data_item.address_type = type_reg;
                    if (bytes_seen_next == frame_end) begin
                        stat_vld                 = 1'b1;
                        stat_item.status         = ST_SUCCESS;
                        stat_item.consumed_count = bytes_seen_next;
                    end
                end
                default: begin
                end
            endcase

            if (ph_mid == PH_HOLD && bytes_seen_next >= MIN_BUFFER) begin
                stat_vld         = 1'b1;
                stat_item.status = ST_INVALID;
            end

            phase_next = stat_vld ? PH_DONE : ph_mid;

            if (s_tlast) begin
                if (phase_next != PH_DONE) begin
                    stat_vld         = 1'b1;
                    stat_item.status = ST_INCOMPLETE;
                end
                phase_next      = PH_TYPE;
                bytes_seen_next = '0;
                type_next       = '0;
                fcount_next     = '0;
                dlen_next       = '0;
                port_next       = '0;
                length_next     = '0;
                inv_next        = 1'b0;
            end
        end

        if (stat_vld) begin
            stat_item.last_of_run = 1'b1;
        end else begin
            data_item.last_of_run = 1'b1;
        end
    end

    always_comb begin
        first_item  = data_vld ? data_item : stat_item;
        n_wr        = {1'b0, data_vld} + {1'b0, stat_vld};
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_wr);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LEVEL_W'(n_wr) - LEVEL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TYPE;
            bytes_seen_reg <= '0;
            type_reg       <= '0;
            fcount_reg     <= '0;
            dlen_reg       <= '0;
            port_reg       <= '0;
            length_reg     <= '0;
            inv_reg        <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            level_reg      <= '0;
        end else begin
            phase_reg      <= phase_next;
            bytes_seen_reg <= bytes_seen_next;
            type_reg       <= type_next;
            fcount_reg     <= fcount_next;
            dlen_reg       <= dlen_next;
            port_reg       <= port_next;
            length_reg     <= length_next;
            inv_reg        <= inv_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            level_reg      <= level_next;
            if (data_vld || stat_vld) begin
                fifo_reg[wr_ptr_reg] <= first_item;
            end
            if (data_vld && stat_vld) begin
                fifo_reg[wr_ptr_reg + PTR_W'(1)] <= stat_item;
            end
        end
    end

endmodule

### hdl/saufp_checker.sv
// ----------------------------------------------------------------------------
// saufp_checker
// Port-level checks on the frame parser's result channel and input ready.
// ----------------------------------------------------------------------------
module saufp_checker
    import saufp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser,
    input logic                 m_tlast
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result channel valid or input blocked right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
        else $error("status item not marked last of run");

    a_data_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_STATUS |-> m_tdata[66:48] == '0)
        else $error("data item carries status or count");

    a_count_only_success: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS && m_tdata[49:48] != ST_SUCCESS
            |-> m_tdata[66:50] == '0)
        else $error("consumed count on a failed status");

endmodule

bind socks_address_udp_frame_parser saufp_checker u_saufp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### dv/frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_parser_checker
// Watches both streams of the UDP frame parser. Every accepted input byte
// runs through a byte-serial model of the parse. The model keeps its own copy
// of the parse state and queues the result items that the byte should cause.
// Each accepted result item is compared field by field with the oldest queued
// item. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module frame_parser_checker
    import saufp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 m_tlast,
    output int                   mismatch_count,
    output int                   awaited_results
);

    typedef enum logic [3:0] {
        WAIT_TYPE,
        GET_DLEN,
        GET_ADDR,
        GET_PORT_HI,
        GET_PORT_LO,
        GET_LEN_HI,
        GET_LEN_LO,
        GET_CR,
        GET_LF,
        PASS_PAYLOAD,
        HOLD_INVALID,
        DRAIN
    } parse_phase_t;

    parse_phase_t       phase_q;
    logic [COUNT_W-1:0] seen_cnt;
    logic [7:0]         atype_q;
    logic [7:0]         addr_left;
    logic [7:0]         dom_len;
    logic [WORD_W-1:0]  port_q;
    logic [WORD_W-1:0]  plen_q;
    logic               bad_pending;
    out_item_t          expected_q[$];

    initial begin
        mismatch_count  = 0;
        awaited_results = 0;
    end

    function automatic void clear_parse();
        phase_q     = WAIT_TYPE;
        seen_cnt    = '0;
        atype_q     = '0;
        addr_left   = '0;
        dom_len     = '0;
        port_q      = '0;
        plen_q      = '0;
        bad_pending = 1'b0;
    endfunction

    function automatic void enqueue_item(out_item_t item);
        expected_q.insert(expected_q.size(), item);
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] b,
                                 logic [WORD_W-1:0] port, logic [WORD_W-1:0] plen);
        out_item_t item;
        item                = '0;
        item.kind           = kind;
        item.out_byte       = b;
        item.address_type   = atype_q;
        item.port_number    = port;
        item.payload_length = plen;
        enqueue_item(item);
    endfunction

    function automatic void close_frame(logic [1:0] status, logic [COUNT_W-1:0] consumed);
        out_item_t item;
        item                = '0;
        item.kind           = KIND_STATUS;
        item.status         = status;
        item.consumed_count = consumed;
        enqueue_item(item);
        phase_q = DRAIN;
    endfunction

    function automatic logic [COUNT_W-1:0] frame_total();
        logic [8:0] hdr;
        if (atype_q == ATYPE_IPV4) begin
            hdr = HDR_IPV4;
        end else if (atype_q == ATYPE_IPV6) begin
            hdr = HDR_IPV6;
        end else begin
            hdr = HDR_DOMAIN_0 + 9'(dom_len);
        end
        return COUNT_W'(hdr) + COUNT_W'(plen_q);
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        int before_n;
        before_n = expected_q.size();
        if (phase_q != DRAIN) begin
            seen_cnt = seen_cnt + COUNT_W'(1);
        end
        case (phase_q)
            WAIT_TYPE: begin
                atype_q = b;
                if (b == ATYPE_IPV4) begin
                    addr_left = IPV4_ADDR_LEN;
                    phase_q   = GET_ADDR;
                end else if (b == ATYPE_IPV6) begin
                    addr_left = IPV6_ADDR_LEN;
                    phase_q   = GET_ADDR;
                end else if (b == ATYPE_DOMAIN) begin
                    phase_q = GET_DLEN;
                end else begin
                    bad_pending = 1'b1;
                    phase_q     = HOLD_INVALID;
                end
            end
            GET_DLEN: begin
                dom_len = b;
                if (b == 8'd0 || b > DOMAIN_MAX) begin
                    bad_pending = 1'b1;
                    phase_q     = HOLD_INVALID;
                end else begin
                    addr_left = b;
                    phase_q   = GET_ADDR;
                end
            end
            GET_ADDR: begin
                emit(KIND_ADDR, b, '0, '0);
                addr_left = addr_left - 8'd1;
                if (addr_left == 8'd0) begin
                    phase_q = GET_PORT_HI;
                end
            end
            GET_PORT_HI: begin
                port_q  = {b, 8'd0};
                phase_q = GET_PORT_LO;
            end
            GET_PORT_LO: begin
                port_q  = {port_q[15:8], b};
                phase_q = GET_LEN_HI;
            end
            GET_LEN_HI: begin
                plen_q  = {b, 8'd0};
                phase_q = GET_LEN_LO;
            end
            GET_LEN_LO: begin
                plen_q  = {plen_q[15:8], b};
                phase_q = GET_CR;
            end
            GET_CR: begin
                bad_pending = (b != CHAR_CR);
                phase_q     = GET_LF;
            end
            GET_LF: begin
                if (bad_pending || b != CHAR_LF) begin
                    close_frame(ST_INVALID, '0);
                end else begin
                    emit(KIND_HEADER, 8'd0, port_q, plen_q);
                    if (plen_q == '0) begin
                        close_frame(ST_SUCCESS, seen_cnt);
                    end else begin
                        phase_q = PASS_PAYLOAD;
                    end
                end
            end
            PASS_PAYLOAD: begin
                emit(KIND_PAYLOAD, b, '0, '0);
                if (seen_cnt == frame_total()) begin
                    close_frame(ST_SUCCESS, seen_cnt);
                end
            end
            default: begin
            end
        endcase
        if (phase_q == HOLD_INVALID && seen_cnt >= MIN_BUFFER) begin
            close_frame(ST_INVALID, '0);
        end
        if (last) begin
            if (phase_q != DRAIN) begin
                close_frame(ST_INCOMPLETE, '0);
            end
            clear_parse();
        end
        if (expected_q.size() > before_n) begin
            expected_q[$].last_of_run = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        out_item_t want;
        if (expected_q.size() == 0) begin
            $error("result item with none expected: kind %0d tdata 0x%0h", m_tuser, m_tdata);
            mismatch_count++;
        end else begin
            want = expected_q.pop_front();
            check_field("kind", 32'(want.kind), 32'(m_tuser));
            check_field("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
            check_field("address_type", 32'(want.address_type), 32'(m_tdata[15:8]));
            check_field("port_number", 32'(want.port_number), 32'(m_tdata[31:16]));
            check_field("payload_length", 32'(want.payload_length), 32'(m_tdata[47:32]));
            check_field("status", 32'(want.status), 32'(m_tdata[49:48]));
            check_field("consumed_count", 32'(want.consumed_count), 32'(m_tdata[66:50]));
            check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
        end
    endfunction

    // compare before predicting: a result never stems from a byte taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
            end
        end
        awaited_results = expected_q.size();
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the UDP frame parser. Sends a few hand-built
// buffers, then random buffers: mostly well-formed frames of every address
// type with random content, plus bad types, bad domain lengths, CR LF
// mismatches, trailing bytes and cut buffers. Both sides idle at random, and
// the receiver twice stalls for a long stretch so the parser backs up.
// ----------------------------------------------------------------------------
module testbench
    import saufp_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 700;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'd0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    int         mismatch_count;
    int         awaited_results;
    int         cycle_count = 0;
    int         bytes_sent  = 0;
    bit         src_idle    = 1'b1;
    logic [7:0] frame_q[$];

    always #1 aclk = ~aclk;

    socks_address_udp_frame_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    frame_parser_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .awaited_results (awaited_results)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void add_byte(logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endfunction

    task automatic send_frame();
        int gap;
        for (int i = 0; i < frame_q.size(); i++) begin
            gap = src_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            do @(posedge aclk); while (!s_tready);
            bytes_sent++;
        end
    endtask

    task automatic build_frame();
        logic [7:0] atype;
        int         addr_n;
        int         plen;
        int         pick;
        int         cut;
        frame_q.delete();
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            atype = ATYPE_IPV4;
        end else if (pick < 12) begin
            atype = ATYPE_DOMAIN;
        end else if (pick < 18) begin
            atype = ATYPE_IPV6;
        end else begin
            atype = 8'($urandom_range(0, 255));
        end
        add_byte(atype);
        addr_n = int'(IPV4_ADDR_LEN);
        if (atype == ATYPE_IPV6) begin
            addr_n = int'(IPV6_ADDR_LEN);
        end else if (atype == ATYPE_DOMAIN) begin
            pick = $urandom_range(0, 49);
            if (pick == 0) begin
                addr_n = 0;
            end else if (pick == 1) begin
                addr_n = $urandom_range(254, 255);
            end else if (pick == 2) begin
                addr_n = int'(DOMAIN_MAX);
            end else begin
                addr_n = $urandom_range(1, 12);
            end
            add_byte(8'(addr_n));
            if (addr_n == 0 || addr_n > int'(DOMAIN_MAX)) begin
                addr_n = int'(IPV4_ADDR_LEN);
            end
        end
        repeat (addr_n) add_byte(8'($urandom));
        repeat (2) add_byte(8'($urandom));
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 10);
        add_byte(8'(plen >> 8));
        add_byte(8'(plen));
        add_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : CHAR_CR);
        add_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : CHAR_LF);
        repeat ((plen > 24) ? 24 : plen) add_byte(8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) frame_q.pop_back();
        end
    endtask

    initial begin
        int gap;
        int taken;
        bit idle_on;
        taken   = 0;
        idle_on = 1'b1;
        wait (aresetn);
        forever begin
            if (taken % 40 == 0) begin
                idle_on = $urandom_range(0, 1);
            end
            gap = idle_on ? $urandom_range(0, 15) : 0;
            // hold off long enough for the parser to fill and stall its input
            if (taken == 120 || taken == 380) begin
                gap = 400;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        frame_q = '{ATYPE_IPV4};
        send_frame();
        frame_q = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'h02, 8'h03};
        send_frame();
        frame_q = '{ATYPE_DOMAIN, 8'h00, 8'h41};
        send_frame();
        frame_q = '{ATYPE_IPV4, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00,
                    8'h0C, CHAR_LF, 8'h77};
        send_frame();
        frame_q = '{ATYPE_IPV4, 8'hC0, 8'hA8, 8'h00, 8'h01, 8'h00, 8'h35, 8'h00, 8'h00,
                    CHAR_CR, CHAR_LF};
        send_frame();

        while (bytes_sent < RANDOM_BYTES) begin
            src_idle = ($urandom_range(0, 2) != 0);
            build_frame();
            send_frame();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge aclk);
        wait (awaited_results == 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
